FILE: sv/brf_pkg.sv
package brf_pkg;

  // input item kinds, carried on in_tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int unsigned CAP_W      = 9;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input item taken this cycle
    logic is_pop;   // taken item is a pop
  } brf_cmd_t;

endpackage

FILE: sv/byte_ring_fifo_core.sv
// Byte ring FIFO. Each input item is a push (in_tuser = 0, byte in in_tdata)
// or a pop (in_tuser = 1); each produces exactly one result item reporting
// success, the popped byte (0 unless a pop succeeded), the occupancy after
// the step and the wrapping 32-bit count of pushes dropped on a full ring.
// One slot of the ring always stays empty, so at most capacity - 1 bytes
// are held; a capacity below 2 rejects every push without counting it, and
// a capacity above DEPTH acts as DEPTH. Writing cfg_wr_data (only while the
// block is idle) sets the capacity and clears both indices and the drop
// count; stored bytes are kept. Timing: a push result is ready the cycle
// after the push is taken, so pushes run at one item per cycle while each
// result is taken at once; a pop passes through ST_READ, as the byte store
// has a registered read port, and takes no new item there. The result sits
// in an output register, and a new item may enter in the same cycle it is taken.
module byte_ring_fifo_core #(
  parameter int unsigned DEPTH = 256   // store size, 2 to 65535
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [brf_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] push_data
  input  logic                           in_tuser,   // [0] operation: 0 push, 1 pop
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [brf_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] accepted, [8:1] pop_data,
                                                     // [16:9] occupancy,
                                                     // [48:17] dropped_count, rest 0
  // capacity register
  input  logic                           cfg_wr_en,
  input  logic [brf_pkg::CAP_W-1:0]      cfg_wr_data // ring_capacity
);
  import brf_pkg::*;

  brf_cmd_t cmd;

  // handshake and pop sequencing
  brf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // indices, drop counter, byte store, result register
  brf_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .push_data   (in_tdata[BYTE_W-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (out_tdata)
  );

endmodule

FILE: sv/brf_ctrl.sv
module brf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_op,
  input  logic            out_tready,
  output logic            in_tready,
  output logic            out_tvalid,
  output brf_pkg::brf_cmd_t cmd
);
  import brf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign take       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  assign cmd.accept = take;
  assign cmd.is_pop = (in_op == OP_POP);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_op == OP_POP) begin
            // the store read is registered, so wait in ST_READ
            state_nxt     = ST_READ;
            out_valid_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/brf_datapath.sv
module brf_datapath #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  brf_pkg::brf_cmd_t                 cmd,
  input  logic [brf_pkg::BYTE_W-1:0]        push_data,
  input  logic                              cfg_wr_en,
  input  logic [brf_pkg::CAP_W-1:0]         cfg_wr_data,
  output logic [brf_pkg::OUT_DATA_W-1:0]    result
);
  import brf_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // wide enough for capacity, DEPTH and index + 1
  localparam int unsigned SW = ((IW + 1) > CAP_W) ? (IW + 1) : CAP_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [SW-1:0] TWO_S   = SW'(2);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]  cap_r;
  logic [IW-1:0]     w_idx_r, w_idx_nxt;
  logic [IW-1:0]     r_idx_r, r_idx_nxt;
  logic [CNT_W-1:0]  drop_r, drop_nxt;
  logic              ok_r, ok_nxt;
  logic              pop_ok_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] occ_r;

  logic [SW-1:0] cap_ext, cap_eff, w_ext, r_ext, w_inc, r_inc;
  logic [SW-1:0] w_adv, r_adv, w_new, r_new, held;
  logic          can_push, full, not_empty, do_write;

  always_comb begin
    cap_ext   = SW'(cap_r);
    cap_eff   = (cap_ext > DEPTH_S) ? DEPTH_S : cap_ext;
    w_ext     = SW'(w_idx_r);
    r_ext     = SW'(r_idx_r);
    w_inc     = w_ext + SW'(1);
    r_inc     = r_ext + SW'(1);
    w_adv     = (w_inc >= cap_eff) ? '0 : w_inc;
    r_adv     = (r_inc >= cap_eff) ? '0 : r_inc;
    can_push  = (cap_eff >= TWO_S);
    full      = (w_adv == r_ext);
    not_empty = (w_idx_r != r_idx_r);

    w_idx_nxt = w_idx_r;
    r_idx_nxt = r_idx_r;
    drop_nxt  = drop_r;
    ok_nxt    = 1'b0;
    do_write  = 1'b0;

    if (cmd.is_pop) begin
      if (not_empty) begin
        r_idx_nxt = r_adv[IW-1:0];
        ok_nxt    = 1'b1;
      end
    end else if (can_push) begin
      if (full) begin
        drop_nxt = drop_r + CNT_W'(1);
      end else begin
        w_idx_nxt = w_adv[IW-1:0];
        ok_nxt    = 1'b1;
        do_write  = 1'b1;
      end
    end

    // occupancy after the step, wrap aware
    w_new = SW'(w_idx_nxt);
    r_new = SW'(r_idx_nxt);
    held  = (w_new >= r_new) ? (w_new - r_new) : (cap_eff - r_new + w_new);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && do_write) begin
      mem[w_idx_r] <= push_data;
    end
    if (cmd.accept && cmd.is_pop) begin
      rd_data_r <= mem[r_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      w_idx_r <= '0;
      r_idx_r <= '0;
      drop_r  <= '0;
    end else if (cfg_wr_en) begin
      cap_r   <= cfg_wr_data;
      w_idx_r <= '0;
      r_idx_r <= '0;
      drop_r  <= '0;
    end else if (cmd.accept) begin
      w_idx_r <= w_idx_nxt;
      r_idx_r <= r_idx_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ok_r     <= ok_nxt;
      pop_ok_r <= ok_nxt && cmd.is_pop;
      occ_r    <= held[BYTE_W-1:0];
    end
  end

  assign result = {7'd0, drop_r, occ_r,
                   (pop_ok_r ? rd_data_r : {BYTE_W{1'b0}}), ok_r};

endmodule

FILE: sv/brf_checker.sv
module brf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [brf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import brf_pkg::*;

  // a new item is never taken over a result that is still stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("item taken while result stalled");

  // a push gives its result on the next cycle
  a_push_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_PUSH)) |=> out_tvalid)
    else $error("push result late");

  // a pop holds off its result and new items while the store is read, then gives its result
  a_pop_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_POP)) |=> (!out_tvalid && !in_tready)
    ##1 out_tvalid)
    else $error("pop sequencing broken");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind byte_ring_fifo_core brf_checker u_brf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
